// File: sv/vn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg
// Shared constants for the 3D vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

   localparam int COMP_WIDTH     = 16;
   localparam int OUT_FRAC_BITS  = 14;
   localparam int MIN_LEN_WIDTH  = 16;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [MIN_LEN_WIDTH-1:0] MIN_LENGTH_RESET = 16'd1;

   // register indexes (word address = byte address / 4)
   localparam logic [0:0] REG_MIN_LENGTH = 1'b0;

endpackage

// File: sv/vector3_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize
// Euclidean length and unit vector of a signed Q8.8 3D vector.
// ----------------------------------------------------------------------------
//   channel   direction  contents
//   req_*     in         comp_x, comp_y, comp_z
//   rsp_*     out        out_x, out_y, out_z, vec_length; tuser = normalized
//   csr_*     in/out     min_length at byte address 0
//
// One vector per cycle unless the output stalls; stages: capture, squares,
// sum, one square-root cell per root bit, a decision stage, one divide cell
// per numerator bit, output register. A stalled output holds the whole chain.
// Synchronous reset empties the chain and sets min_length to 1.
// ----------------------------------------------------------------------------
module vector3_normalize #(
   parameter int COMP_WIDTH    = vn_pkg::COMP_WIDTH,
   parameter int OUT_FRAC_BITS = vn_pkg::OUT_FRAC_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // comp_x, comp_y, comp_z from bit 0 up, zero padded
   input  logic [((3*COMP_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // out_x, out_y, out_z, vec_length from bit 0 up, zero padded
   output logic [((4*COMP_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // normalized
   output logic [0:0]                        rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vn_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [vn_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [vn_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                              csr_pready
);
   import vn_pkg::*;

   localparam int W      = COMP_WIDTH;
   localparam int F      = OUT_FRAC_BITS;
   localparam int NB     = W + F;
   localparam int OUT_DW = ((4*W+7)/8)*8;

   logic advance;

   // configuration
   logic [MIN_LEN_WIDTH-1:0] min_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MIN_LENGTH_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_MIN_LENGTH) begin
         min_len_ff <= csr_pwdata[MIN_LEN_WIDTH-1:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_MIN_LENGTH)
                       ? CSR_DATA_WIDTH'(min_len_ff) : '0;

   assign req_tready = advance;

   // stage 0: capture and take magnitudes
   logic               s0_valid_ff;
   logic [3*W-1:0]     s0_raw_ff;
   logic [2:0][W-1:0]  s0_mag_ff, s0_mag_in;
   logic [2:0][W-1:0]  in_comp;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_comp[i]   = req_tdata[i*W +: W];
         s0_mag_in[i] = in_comp[i][W-1] ? W'(~in_comp[i] + 1'b1) : in_comp[i];
      end
   end

   // stage 1: squares; stage 2: sum
   logic                s1_valid_ff;
   logic [3*W-1:0]      s1_raw_ff;
   logic [2:0][2*W-1:0] s1_sq_ff;
   logic                s2_valid_ff;
   logic [3*W-1:0]      s2_raw_ff;
   logic [2*W-1:0]      s2_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_tvalid;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_raw_ff <= req_tdata[3*W-1:0];
         s0_mag_ff <= s0_mag_in;
         s1_raw_ff <= s0_raw_ff;
         for (int i = 0; i < 3; i++) begin
            s1_sq_ff[i] <= s0_mag_ff[i] * s0_mag_ff[i];
         end
         s2_raw_ff <= s1_raw_ff;
         s2_sum_ff <= s1_sq_ff[0] + s1_sq_ff[1] + s1_sq_ff[2];
      end
   end

   // square-root chain
   logic           sq_valid [W+1];
   logic [2*W-1:0] sq_rad   [W+1];
   logic [W+1:0]   sq_rem   [W+1];
   logic [W-1:0]   sq_root  [W+1];
   logic [3*W-1:0] sq_raw   [W+1];

   assign sq_valid[0] = s2_valid_ff;
   assign sq_rad[0]   = s2_sum_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_raw[0]   = s2_raw_ff;

   for (genvar g = 0; g < W; g++) begin : g_sqrt
      vn_sqrt_cell #(.W(W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (sq_valid[g]),
         .rad_in    (sq_rad[g]),
         .rem_in    (sq_rem[g]),
         .root_in   (sq_root[g]),
         .raw_in    (sq_raw[g]),
         .valid_out (sq_valid[g+1]),
         .rad_out   (sq_rad[g+1]),
         .rem_out   (sq_rem[g+1]),
         .root_out  (sq_root[g+1]),
         .raw_out   (sq_raw[g+1])
      );
   end

   // decision stage: compare against min_length, set up numerators
   logic               dc_valid_ff;
   logic               dc_norm_ff, dc_norm_in;
   logic [W-1:0]       dc_len_ff;
   logic [3*W-1:0]     dc_raw_ff;
   logic [2:0][NB-1:0] dc_num_ff, dc_num_in;
   logic [W-1:0]       len_w;
   logic [W-1:0]       comp_w;
   logic [W-1:0]       mag_w;

   always_comb begin
      len_w      = sq_root[W];
      dc_norm_in = (len_w != '0) && ((W+16)'(len_w) >= (W+16)'(min_len_ff));
      comp_w     = '0;
      mag_w      = '0;
      for (int i = 0; i < 3; i++) begin
         comp_w       = sq_raw[W][i*W +: W];
         mag_w        = comp_w[W-1] ? W'(~comp_w + 1'b1) : comp_w;
         dc_num_in[i] = {mag_w, {F{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_valid_ff <= 1'b0;
      end else if (advance) begin
         dc_valid_ff <= sq_valid[W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dc_norm_ff <= dc_norm_in;
         dc_len_ff  <= len_w;
         dc_raw_ff  <= sq_raw[W];
         dc_num_ff  <= dc_num_in;
      end
   end

   // divide chain
   logic               dv_valid [NB+1];
   logic               dv_norm  [NB+1];
   logic [W-1:0]       dv_den   [NB+1];
   logic [3*W-1:0]     dv_raw   [NB+1];
   logic [2:0][NB-1:0] dv_num   [NB+1];
   logic [2:0][W-1:0]  dv_rem   [NB+1];
   logic [2:0][W-1:0]  dv_quo   [NB+1];

   assign dv_valid[0] = dc_valid_ff;
   assign dv_norm[0]  = dc_norm_ff;
   assign dv_den[0]   = dc_len_ff;
   assign dv_raw[0]   = dc_raw_ff;
   assign dv_num[0]   = dc_num_ff;
   assign dv_rem[0]   = '0;
   assign dv_quo[0]   = '0;

   for (genvar g = 0; g < NB; g++) begin : g_div
      vn_div_cell #(.W(W), .NB(NB)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (dv_valid[g]),
         .norm_in   (dv_norm[g]),
         .den_in    (dv_den[g]),
         .raw_in    (dv_raw[g]),
         .num_in    (dv_num[g]),
         .rem_in    (dv_rem[g]),
         .quo_in    (dv_quo[g]),
         .valid_out (dv_valid[g+1]),
         .norm_out  (dv_norm[g+1]),
         .den_out   (dv_den[g+1]),
         .raw_out   (dv_raw[g+1]),
         .num_out   (dv_num[g+1]),
         .rem_out   (dv_rem[g+1]),
         .quo_out   (dv_quo[g+1])
      );
   end

   // output register: apply signs or pass the input through
   logic              out_valid_ff;
   logic              out_norm_ff;
   logic [W-1:0]      out_len_ff;
   logic [2:0][W-1:0] out_comp_ff, out_comp_in;
   logic [W-1:0]      raw_c;
   logic [W-1:0]      quo_c;

   always_comb begin
      raw_c = '0;
      quo_c = '0;
      for (int i = 0; i < 3; i++) begin
         raw_c = dv_raw[NB][i*W +: W];
         quo_c = dv_quo[NB][i];
         if (dv_norm[NB]) begin
            out_comp_in[i] = raw_c[W-1] ? W'(~quo_c + 1'b1) : quo_c;
         end else begin
            out_comp_in[i] = raw_c;
         end
      end
   end

   assign advance = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= dv_valid[NB];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_norm_ff <= dv_norm[NB];
         out_len_ff  <= dv_den[NB];
         out_comp_ff <= out_comp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_norm_ff;
   assign rsp_tdata  = OUT_DW'({out_len_ff, out_comp_ff[2], out_comp_ff[1], out_comp_ff[0]});

endmodule

// File: sv/vn_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_sqrt_cell
// One digit of the integer square root: takes two radicand bits, settles one
// root bit, and hands the partial result and the vector on to the next cell.
// ----------------------------------------------------------------------------
module vn_sqrt_cell #(
   parameter int W = vn_pkg::COMP_WIDTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           valid_in,
   input  logic [2*W-1:0] rad_in,
   input  logic [W+1:0]   rem_in,
   input  logic [W-1:0]   root_in,
   input  logic [3*W-1:0] raw_in,
   output logic           valid_out,
   output logic [2*W-1:0] rad_out,
   output logic [W+1:0]   rem_out,
   output logic [W-1:0]   root_out,
   output logic [3*W-1:0] raw_out
);
   import vn_pkg::*;

   logic           valid_ff;
   logic [2*W-1:0] rad_ff, rad_in_nx;
   logic [W+1:0]   rem_ff, rem_in_nx;
   logic [W-1:0]   root_ff, root_in_nx;
   logic [3*W-1:0] raw_ff;
   logic [W+3:0]   shifted;
   logic [W+3:0]   trial;
   logic [W+3:0]   diff;
   logic           take;

   always_comb begin
      shifted    = {rem_in, rad_in[2*W-1 -: 2]};
      trial      = {2'b00, root_in, 2'b01};
      take       = (shifted >= trial);
      diff       = shifted - trial;
      rem_in_nx  = take ? diff[W+1:0] : shifted[W+1:0];
      root_in_nx = {root_in[W-2:0], take};
      rad_in_nx  = {rad_in[2*W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff  <= rad_in_nx;
         rem_ff  <= rem_in_nx;
         root_ff <= root_in_nx;
         raw_ff  <= raw_in;
      end
   end

   assign valid_out = valid_ff;
   assign rad_out   = rad_ff;
   assign rem_out   = rem_ff;
   assign root_out  = root_ff;
   assign raw_out   = raw_ff;

endmodule

// File: sv/vn_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_div_cell
// One quotient bit of restoring division for all three components, with the
// length, the raw vector and the normalize flag riding along.
// ----------------------------------------------------------------------------
module vn_div_cell #(
   parameter int W  = vn_pkg::COMP_WIDTH,
   parameter int NB = vn_pkg::COMP_WIDTH + vn_pkg::OUT_FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                valid_in,
   input  logic                norm_in,
   input  logic [W-1:0]        den_in,
   input  logic [3*W-1:0]      raw_in,
   input  logic [2:0][NB-1:0]  num_in,
   input  logic [2:0][W-1:0]   rem_in,
   input  logic [2:0][W-1:0]   quo_in,
   output logic                valid_out,
   output logic                norm_out,
   output logic [W-1:0]        den_out,
   output logic [3*W-1:0]      raw_out,
   output logic [2:0][NB-1:0]  num_out,
   output logic [2:0][W-1:0]   rem_out,
   output logic [2:0][W-1:0]   quo_out
);
   import vn_pkg::*;

   logic               valid_ff;
   logic               norm_ff;
   logic [W-1:0]       den_ff;
   logic [3*W-1:0]     raw_ff;
   logic [2:0][NB-1:0] num_ff, num_in_nx;
   logic [2:0][W-1:0]  rem_ff, rem_in_nx;
   logic [2:0][W-1:0]  quo_ff, quo_in_nx;
   logic [W:0]         trial;
   logic               take;

   always_comb begin
      trial = '0;
      take  = 1'b0;
      for (int i = 0; i < 3; i++) begin
         trial        = {rem_in[i], num_in[i][NB-1]};
         take         = (trial >= {1'b0, den_in});
         rem_in_nx[i] = take ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
         quo_in_nx[i] = {quo_in[i][W-2:0], take};
         num_in_nx[i] = {num_in[i][NB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         norm_ff <= norm_in;
         den_ff  <= den_in;
         raw_ff  <= raw_in;
         num_ff  <= num_in_nx;
         rem_ff  <= rem_in_nx;
         quo_ff  <= quo_in_nx;
      end
   end

   assign valid_out = valid_ff;
   assign norm_out  = norm_ff;
   assign den_out   = den_ff;
   assign raw_out   = raw_ff;
   assign num_out   = num_ff;
   assign rem_out   = rem_ff;
   assign quo_out   = quo_ff;

endmodule

// File: sv/vn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_port_checks
// Port-level checks for the vector normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module vn_port_checks #(
   parameter int W = vn_pkg::COMP_WIDTH
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic [((4*W+7)/8)*8-1:0]          rsp_tdata,
   input logic [0:0]                        rsp_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic                              csr_pready
);
   import vn_pkg::*;

   // a waiting result keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a normalized result always has a nonzero length
   a_norm_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[4*W-1:3*W] != '0)
      else $error("normalized with zero length");

   // a stalled output holds off new input
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result right after reset");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind vector3_normalize vn_port_checks #(.W(COMP_WIDTH)) u_vn_port_checks (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .csr_pready (csr_pready)
);

// File: sim/vn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_checker
// Watches the vector, result and register ports of vector3_normalize,
// predicts each result from the accepted vector and the tracked min_length,
// and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module vn_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [47:0]                       req_tdata,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [63:0]                       rsp_tdata,
   input  logic [0:0]                        rsp_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vn_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [vn_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  logic                              csr_pready,
   output int                                errors,
   output int                                pending
);
   import vn_pkg::*;

   typedef struct packed {
      logic [15:0] out_x;
      logic [15:0] out_y;
      logic [15:0] out_z;
      logic [15:0] vec_length;
      logic        normalized;
   } unit_vec_type;

   unit_vec_type               unit_q[$];
   logic [MIN_LEN_WIDTH-1:0]   min_len;

   assign pending = unit_q.size();

   function automatic logic [63:0] floor_sqrt(logic [63:0] v);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v    = v - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic unit_vec_type normalize_vec(logic [47:0] data, logic [15:0] min_l);
      unit_vec_type r;
      logic [15:0]  raw [3];
      logic [63:0]  mag [3];
      logic [63:0]  sum;
      logic [63:0]  len;
      logic [63:0]  q;
      logic [15:0]  res [3];
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         raw[i] = data[16*i +: 16];
         mag[i] = raw[i][15] ? (64'd65536 - raw[i]) : {48'd0, raw[i]};
         sum    = sum + mag[i] * mag[i];
      end
      len = floor_sqrt(sum);
      r.normalized = (len != 0) && (len >= min_l);
      for (int i = 0; i < 3; i++) begin
         if (r.normalized) begin
            q      = (mag[i] << OUT_FRAC_BITS) / len;
            res[i] = raw[i][15] ? 16'(-q) : q[15:0];
         end else begin
            res[i] = raw[i];
         end
      end
      r.out_x      = res[0];
      r.out_y      = res[1];
      r.out_z      = res[2];
      r.vec_length = len[15:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      $display("%0t: %s got %h, expected %h", $realtime, field, got, want);
      errors++;
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      unit_vec_type w;
      if (reset) begin
         min_len = MIN_LENGTH_RESET;
         unit_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && (csr_paddr >> 2) == REG_MIN_LENGTH)
            min_len = csr_pwdata[MIN_LEN_WIDTH-1:0];
         if (req_tvalid && req_tready)
            unit_q.push_back(normalize_vec(req_tdata, min_len));
         if (rsp_tvalid && rsp_tready) begin
            if (unit_q.size() == 0) begin
               $display("%0t: result transfer with none outstanding", $realtime);
               errors++;
            end else begin
               w = unit_q.pop_front();
               if (rsp_tdata[15:0] !== w.out_x)
                  report_mismatch("out_x", rsp_tdata[15:0], w.out_x);
               if (rsp_tdata[31:16] !== w.out_y)
                  report_mismatch("out_y", rsp_tdata[31:16], w.out_y);
               if (rsp_tdata[47:32] !== w.out_z)
                  report_mismatch("out_z", rsp_tdata[47:32], w.out_z);
               if (rsp_tdata[63:48] !== w.vec_length)
                  report_mismatch("vec_length", rsp_tdata[63:48], w.vec_length);
               if (rsp_tuser[0] !== w.normalized)
                  report_mismatch("normalized", {15'd0, rsp_tuser[0]},
                                  {15'd0, w.normalized});
            end
         end
      end
   end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives vector3_normalize with directed and random vectors across several
// min_length settings and idle patterns; vn_checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
   import vn_pkg::*;

   localparam int LATENCY = 2*COMP_WIDTH + OUT_FRAC_BITS + 5;
   localparam int LIMIT   = 400000;

   logic        clock;
   logic        reset;
   logic [47:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic        csr_pready;
   int          errors;
   int          pending;
   int          cycles;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          hold_cycles;

   vector3_normalize i_dut (.*);

   vn_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("vector3_normalize: mismatch");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off when requested
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_ADDR_WIDTH-1:0] addr, logic [31:0] value);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [15:0] rand_comp(int mode);
      case (mode)
         0:       return 16'($urandom);
         1:       return 16'($urandom_range(2047)) - 16'd1024;
         2:       return 16'($urandom_range(15)) - 16'd8;
         default: return ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
      endcase
   endfunction

   task automatic send_random(int count);
      int mode;
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(9);
         mode = (mode < 5) ? 0 : (mode < 8) ? 1 : (mode < 9) ? 2 : 3;
         send_vec(rand_comp(mode), rand_comp(mode), ($urandom_range(3) == 0)
                  ? rand_comp(0) : rand_comp(mode));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      cycles = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: zero, extremes, axes, lengths at the reset threshold
      send_vec(16'h0000, 16'h0000, 16'h0000);
      send_vec(16'h8000, 16'h8000, 16'h8000);
      send_vec(16'h7fff, 16'h7fff, 16'h7fff);
      send_vec(16'h8000, 16'h7fff, 16'h0000);
      send_vec(16'h0100, 16'h0000, 16'h0000);
      send_vec(16'h0000, 16'hff00, 16'h0000);
      send_vec(16'h0000, 16'h0000, 16'h0001);
      send_vec(16'hffff, 16'h0000, 16'h0000);
      send_vec(16'h0001, 16'h0001, 16'h0001);
      send_vec(16'h0300, 16'h0400, 16'h0000);
      send_vec(16'hffff, 16'hffff, 16'hffff);
      send_vec(16'h5555, 16'haaaa, 16'h0f0f);
      drain();

      // minimum zero: the zero vector still passes through
      write_reg(3'd0, 32'hffff_0000);
      send_vec(16'h0000, 16'h0000, 16'h0000);
      send_vec(16'h0000, 16'h0001, 16'h0000);
      send_random(280);
      drain();

      // maximum: nothing normalizes; sender mostly idle
      write_reg(3'd0, 32'h0000_ffff);
      send_idle_pct = 78;
      send_vec(16'h8000, 16'h8000, 16'h8000);
      send_random(200);
      drain();

      // random threshold; receiver stalls, starting with a long hold-off
      write_reg(3'd0, $urandom_range(65535));
      send_idle_pct = 0;
      recv_stall_pct = 78;
      hold_cycles = 300;
      send_random(300);
      drain();

      // threshold of one unit; both sides lightly idle, pause mid-way
      write_reg(3'd0, 32'd256);
      send_idle_pct = 6;
      recv_stall_pct = 6;
      send_vec(16'h0100, 16'h0000, 16'h0000);
      send_vec(16'h00ff, 16'h0000, 16'h0000);
      send_random(150);
      drain();
      send_random(150);
      drain();

      // write to an address with no register is ignored
      write_reg(3'd0, $urandom_range(2048));
      write_reg(3'd4, 32'h0000_ffff);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_random(250);
      drain();

      if (errors == 0) begin
         $display("vector3_normalize: match");
      end else begin
         $display("vector3_normalize: mismatch");
      end
      $finish;
   end

endmodule
